// File: rtl/dpct_pkg.sv
// ----------------------------------------------------------------------------
// dpct_pkg
// Types and fixed widths shared by the disc pair collision time pipeline.
// ----------------------------------------------------------------------------
package dpct_pkg;

	localparam int POS_W = 20;          // unsigned positions
	localparam int VEL_W = 20;          // signed velocities
	localparam int RAD_W = 19;          // unsigned radii
	localparam int DIF_W = 21;          // signed differences
	localparam int AW    = 42;          // magnitudes of dot products
	localparam int HW    = AW / 2;      // half of a magnitude
	localparam int DDW   = 2 * AW;      // discriminant width
	localparam int RMW   = AW + 4;      // square root partial remainder
	localparam int TW    = 32;          // time width

	typedef struct packed {
		logic                    pair_valid;
		logic [POS_W-1:0]        a_pos_x;
		logic [POS_W-1:0]        a_pos_y;
		logic signed [VEL_W-1:0] a_vel_x;
		logic signed [VEL_W-1:0] a_vel_y;
		logic [RAD_W-1:0]        a_rad;
		logic [POS_W-1:0]        b_pos_x;
		logic [POS_W-1:0]        b_pos_y;
		logic signed [VEL_W-1:0] b_vel_x;
		logic signed [VEL_W-1:0] b_vel_y;
		logic [RAD_W-1:0]        b_rad;
	} in_t;

	typedef struct packed {
		logic          will_hit;
		logic [TW-1:0] hit_time;
	} out_t;

	// travels alongside the square root
	typedef struct packed {
		logic          never;
		logic [AW-1:0] adr;
		logic [AW-1:0] dvdv;
	} sq_sb_t;

	// travels alongside the divider
	typedef struct packed {
		logic hit;
		logic zero;
		logic sat;
	} div_sb_t;

endpackage

// File: rtl/disc_pair_collision_time_top.sv
// ----------------------------------------------------------------------------
// disc_pair_collision_time_top
// Predicts whether two moving discs touch and the time until first contact.
// ----------------------------------------------------------------------------
// Pipeline: 7 front stages, 42 square root stages, 2 compare stages,
// 32 divider stages and 1 output register.
// Throughput: one request per cycle; the whole pipeline holds while a
// result is stalled at the output.
// Reset: arst_n clears all valid bits; data registers are not reset.
module disc_pair_collision_time_top #(
	parameter int FRACTION_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  dpct_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output dpct_pkg::out_t out_data
);

	localparam int AW  = dpct_pkg::AW;
	localparam int HW  = dpct_pkg::HW;
	localparam int DW  = dpct_pkg::DIF_W;
	localparam int DDW = dpct_pkg::DDW;
	localparam int SH  = dpct_pkg::TW - FRACTION_BITS;

	logic ce;

	// pipeline advances unless the output holds an untaken result
	assign in_stall = out_valid && out_stall;
	assign ce       = !in_stall;

	// valid bits for the front and compare stages
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (ce) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// stage 1: offsets and relative velocity
	logic                 pv_s1;
	logic signed [DW-1:0] dx_s1, dy_s1, dvx_s1, dvy_s1;
	logic [DW-2:0]        sig_s1;

	always_ff @(posedge clk) begin
		if (ce) begin
			pv_s1  <= in_data.pair_valid;
			dx_s1  <= $signed({1'b0, in_data.b_pos_x}) - $signed({1'b0, in_data.a_pos_x});
			dy_s1  <= $signed({1'b0, in_data.b_pos_y}) - $signed({1'b0, in_data.a_pos_y});
			dvx_s1 <= DW'(in_data.b_vel_x) - DW'(in_data.a_vel_x);
			dvy_s1 <= DW'(in_data.b_vel_y) - DW'(in_data.a_vel_y);
			sig_s1 <= {1'b0, in_data.a_rad} + {1'b0, in_data.b_rad};
		end
	end

	// stage 2: products
	logic                   pv_s2;
	logic signed [2*DW-1:0] xv_s2, yv_s2, vx2_s2, vy2_s2, dx2_s2, dy2_s2;
	logic [2*DW-3:0]        sg2_s2;

	always_ff @(posedge clk) begin
		if (ce) begin
			pv_s2  <= pv_s1;
			xv_s2  <= dx_s1 * dvx_s1;
			yv_s2  <= dy_s1 * dvy_s1;
			vx2_s2 <= dvx_s1 * dvx_s1;
			vy2_s2 <= dvy_s1 * dvy_s1;
			dx2_s2 <= dx_s1 * dx_s1;
			dy2_s2 <= dy_s1 * dy_s1;
			sg2_s2 <= sig_s1 * sig_s1;
		end
	end

	// stage 3: dot products and the distance excess
	logic                 pv_s3;
	logic signed [AW:0]   dvdr_s3, e_s3;
	logic [AW-1:0]        dvdv_s3;

	always_ff @(posedge clk) begin
		if (ce) begin
			pv_s3   <= pv_s2;
			dvdr_s3 <= (AW+1)'(xv_s2) + (AW+1)'(yv_s2);
			dvdv_s3 <= AW'(vx2_s2) + AW'(vy2_s2);
			e_s3    <= (AW+1)'(dx2_s2) + (AW+1)'(dy2_s2)
			           - $signed({3'b000, sg2_s2});
		end
	end

	// stage 4: early never, magnitudes
	logic          nv_s4, epos_s4;
	logic [AW-1:0] adr_s4, ae_s4, dvdv_s4;

	always_ff @(posedge clk) begin
		if (ce) begin
			nv_s4   <= !pv_s3 || (dvdr_s3 > 0) || (dvdv_s3 == '0);
			epos_s4 <= (e_s3 > 0);
			adr_s4  <= dvdr_s3[AW] ? AW'(-dvdr_s3) : AW'(dvdr_s3);
			ae_s4   <= e_s3[AW] ? AW'(-e_s3) : AW'(e_s3);
			dvdv_s4 <= dvdv_s3;
		end
	end

	// stage 5: half-width partial products of adr^2 and dvdv*|e|
	logic          nv_s5, epos_s5;
	logic [AW-1:0] adr_s5, dvdv_s5;
	logic [AW-1:0] aa_hh_s5, aa_hl_s5, aa_ll_s5;
	logic [AW-1:0] de_hh_s5, de_hl_s5, de_lh_s5, de_ll_s5;

	always_ff @(posedge clk) begin
		if (ce) begin
			nv_s5    <= nv_s4;
			epos_s5  <= epos_s4;
			adr_s5   <= adr_s4;
			dvdv_s5  <= dvdv_s4;
			aa_hh_s5 <= adr_s4[AW-1:HW] * adr_s4[AW-1:HW];
			aa_hl_s5 <= adr_s4[AW-1:HW] * adr_s4[HW-1:0];
			aa_ll_s5 <= adr_s4[HW-1:0] * adr_s4[HW-1:0];
			de_hh_s5 <= dvdv_s4[AW-1:HW] * ae_s4[AW-1:HW];
			de_hl_s5 <= dvdv_s4[AW-1:HW] * ae_s4[HW-1:0];
			de_lh_s5 <= dvdv_s4[HW-1:0] * ae_s4[AW-1:HW];
			de_ll_s5 <= dvdv_s4[HW-1:0] * ae_s4[HW-1:0];
		end
	end

	// stage 6: full products
	logic           nv_s6, epos_s6;
	logic [AW-1:0]  adr_s6, dvdv_s6;
	logic [DDW-1:0] sq_s6, ed_s6;

	always_ff @(posedge clk) begin
		if (ce) begin
			nv_s6   <= nv_s5;
			epos_s6 <= epos_s5;
			adr_s6  <= adr_s5;
			dvdv_s6 <= dvdv_s5;
			sq_s6   <= {aa_hh_s5, {AW{1'b0}}} + (DDW'(aa_hl_s5) << (HW+1))
			           + DDW'(aa_ll_s5);
			ed_s6   <= {de_hh_s5, {AW{1'b0}}}
			           + ((DDW'(de_hl_s5) + DDW'(de_lh_s5)) << HW)
			           + DDW'(de_ll_s5);
		end
	end

	// stage 7: discriminant
	logic             nv_s7;
	logic [AW-1:0]    adr_s7, dvdv_s7;
	logic [DDW-1:0]   d_s7;

	always_ff @(posedge clk) begin
		if (ce) begin
			nv_s7   <= nv_s6 || (epos_s6 && (sq_s6 < ed_s6));
			adr_s7  <= adr_s6;
			dvdv_s7 <= dvdv_s6;
			d_s7    <= epos_s6 ? (sq_s6 - ed_s6) : (sq_s6 + ed_s6);
		end
	end

	// square root of the discriminant
	dpct_pkg::sq_sb_t sq_in, sq_out;
	logic             sq_v;
	logic [AW-1:0]    root;

	assign sq_in.never = nv_s7;
	assign sq_in.adr   = adr_s7;
	assign sq_in.dvdv  = dvdv_s7;

	dpct_isqrt u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.ce    (ce),
		.vin   (v_s7),
		.din   (d_s7),
		.sbin  (sq_in),
		.vout  (sq_v),
		.root  (root),
		.sbout (sq_out)
	);

	// stage 8: numerator and overlap check
	logic          hit_s8, zero_s8;
	logic [AW-1:0] n_s8, dvdv_s8;

	// stage 9: saturation check
	logic          hit_s9, zero_s9, sat_s9;
	logic [AW-1:0] n_s9, dvdv_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (ce) begin
			v_s8 <= sq_v;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			hit_s8  <= !sq_out.never;
			zero_s8 <= (root >= sq_out.adr);
			n_s8    <= sq_out.adr - root;
			dvdv_s8 <= sq_out.dvdv;
			hit_s9  <= hit_s8;
			zero_s9 <= zero_s8;
			sat_s9  <= ((n_s8 >> SH) >= dvdv_s8);
			n_s9    <= n_s8;
			dvdv_s9 <= dvdv_s8;
		end
	end

	// fixed point division
	dpct_pkg::div_sb_t         dv_in, dv_out;
	logic                      dv_v;
	logic [dpct_pkg::TW-1:0]   quo;

	assign dv_in.hit  = hit_s9;
	assign dv_in.zero = zero_s9;
	assign dv_in.sat  = sat_s9;

	dpct_div #(
		.F(FRACTION_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.ce    (ce),
		.vin   (v_s9),
		.num   (n_s9),
		.den   (dvdv_s9),
		.sbin  (dv_in),
		.vout  (dv_v),
		.quo   (quo),
		.sbout (dv_out)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ce) begin
			out_valid <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			out_data.will_hit <= dv_out.hit;
			if (!dv_out.hit || dv_out.zero) begin
				out_data.hit_time <= '0;
			end else if (dv_out.sat) begin
				out_data.hit_time <= '1;
			end else begin
				out_data.hit_time <= quo;
			end
		end
	end

endmodule

// File: rtl/dpct_isqrt.sv
// ----------------------------------------------------------------------------
// dpct_isqrt
// Pipelined floor square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
module dpct_isqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     ce,
	input  logic                     vin,
	input  logic [dpct_pkg::DDW-1:0] din,
	input  dpct_pkg::sq_sb_t         sbin,
	output logic                     vout,
	output logic [dpct_pkg::AW-1:0]  root,
	output dpct_pkg::sq_sb_t         sbout
);

	localparam int NS = dpct_pkg::AW;
	localparam int RMW = dpct_pkg::RMW;

	logic                      v_s   [0:NS];
	logic [dpct_pkg::DDW-1:0]  d_s   [0:NS];
	logic [RMW-1:0]            rem_s [0:NS];
	logic [dpct_pkg::AW-1:0]   rt_s  [0:NS];
	dpct_pkg::sq_sb_t          sb_s  [0:NS];

	assign v_s[0]   = vin;
	assign d_s[0]   = din;
	assign rem_s[0] = '0;
	assign rt_s[0]  = '0;
	assign sb_s[0]  = sbin;

	for (genvar j = 0; j < NS; j++) begin : g_stage
		localparam int K = NS - 1 - j;
		logic [RMW-1:0] rn;
		logic [RMW-1:0] trial;
		logic           ge;

		// bring down two bits, try root*4+1
		assign rn    = {rem_s[j][RMW-3:0], d_s[j][2*K+1:2*K]};
		assign trial = {{(RMW-dpct_pkg::AW-2){1'b0}}, rt_s[j], 2'b01};
		assign ge    = (rn >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (ce) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				d_s[j+1]   <= d_s[j];
				rem_s[j+1] <= ge ? (rn - trial) : rn;
				rt_s[j+1]  <= {rt_s[j][dpct_pkg::AW-2:0], ge};
				sb_s[j+1]  <= sb_s[j];
			end
		end
	end

	assign vout  = v_s[NS];
	assign root  = rt_s[NS];
	assign sbout = sb_s[NS];

endmodule

// File: rtl/dpct_div.sv
// ----------------------------------------------------------------------------
// dpct_div
// Pipelined restoring divider giving floor(n * 2^F / den), one bit per stage.
// ----------------------------------------------------------------------------
module dpct_div #(
	parameter int F = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    ce,
	input  logic                    vin,
	input  logic [dpct_pkg::AW-1:0] num,
	input  logic [dpct_pkg::AW-1:0] den,
	input  dpct_pkg::div_sb_t       sbin,
	output logic                    vout,
	output logic [dpct_pkg::TW-1:0] quo,
	output dpct_pkg::div_sb_t       sbout
);

	localparam int NS = dpct_pkg::TW;
	localparam int AW = dpct_pkg::AW;
	localparam int SH = NS - F;

	logic                v_s [0:NS];
	logic [AW-1:0]       n_s [0:NS];
	logic [AW-1:0]       dn_s[0:NS];
	logic [AW-1:0]       r_s [0:NS];
	logic [NS-1:0]       q_s [0:NS];
	dpct_pkg::div_sb_t   sb_s[0:NS];

	assign v_s[0]  = vin;
	assign n_s[0]  = num;
	assign dn_s[0] = den;
	assign r_s[0]  = num >> SH;    // below den when the quotient fits
	assign q_s[0]  = '0;
	assign sb_s[0] = sbin;

	for (genvar j = 0; j < NS; j++) begin : g_stage
		localparam int I = NS - 1 - j;
		logic          nbit;
		logic [AW:0]   rs;
		logic          ge;
		logic [AW:0]   rd;

		if (I >= F) begin : g_bit
			assign nbit = n_s[j][I-F];
		end else begin : g_zero
			assign nbit = 1'b0;
		end

		assign rs = {r_s[j], nbit};
		assign ge = (rs >= {1'b0, dn_s[j]});
		assign rd = rs - {1'b0, dn_s[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (ce) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				n_s[j+1]  <= n_s[j];
				dn_s[j+1] <= dn_s[j];
				r_s[j+1]  <= ge ? rd[AW-1:0] : rs[AW-1:0];
				q_s[j+1]  <= {q_s[j][NS-2:0], ge};
				sb_s[j+1] <= sb_s[j];
			end
		end
	end

	assign vout  = v_s[NS];
	assign quo   = q_s[NS];
	assign sbout = sb_s[NS];

endmodule

// File: sim/dpct_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dpct_checker
// Watches both channels of the collision time block, computes the expected
// contact flag and time for every accepted request, and compares results.
// ----------------------------------------------------------------------------
module dpct_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_stall,
	input  dpct_pkg::in_t  in_data,
	input  logic           out_valid,
	input  logic           out_stall,
	input  dpct_pkg::out_t out_data,
	output int             errors,
	output int             pending,
	output int             hits_seen,
	output int             sat_seen
);

	localparam int FRAC = 16;

	dpct_pkg::out_t contact_q[$];

	// exact integer square root, floor, of a 96-bit value
	function automatic logic [47:0] root_floor(logic [95:0] v);
		logic [47:0] r;
		logic [47:0] c;
		r = '0;
		for (int b = 47; b >= 0; b--) begin
			c = r | (48'd1 << b);
			if ({48'd0, c} * {48'd0, c} <= v)
				r = c;
		end
		return r;
	endfunction

	// expected result for one pair
	function automatic dpct_pkg::out_t contact_time(dpct_pkg::in_t p);
		dpct_pkg::out_t o;
		logic signed [63:0] dx, dy, dvx, dvy, dvdr, drdr, e, sig2;
		logic [63:0] dvdv, sigma, adr, s, q, t;
		logic [95:0] sq, ed, disc;
		o = '0;
		if (!p.pair_valid)
			return o;
		dx = $signed({44'd0, p.b_pos_x}) - $signed({44'd0, p.a_pos_x});
		dy = $signed({44'd0, p.b_pos_y}) - $signed({44'd0, p.a_pos_y});
		dvx = 64'(p.b_vel_x) - 64'(p.a_vel_x);
		dvy = 64'(p.b_vel_y) - 64'(p.a_vel_y);
		dvdr = dx * dvx + dy * dvy;
		if (dvdr > 0)
			return o;
		dvdv = dvx * dvx + dvy * dvy;
		if (dvdv == 0)
			return o;
		drdr = dx * dx + dy * dy;
		sigma = {45'd0, p.a_rad} + {45'd0, p.b_rad};
		sig2 = sigma * sigma;
		e = drdr - sig2;
		adr = -dvdr;
		sq = {32'd0, adr} * {32'd0, adr};
		ed = {32'd0, dvdv} * {32'd0, (e < 0) ? -e : e};
		if (e <= 0)
			disc = sq + ed;
		else begin
			if (sq < ed)
				return o;
			disc = sq - ed;
		end
		s = {16'd0, root_floor(disc)};
		o.will_hit = 1'b1;
		if (s >= adr)
			return o;
		q = (adr - s) / dvdv;
		if (q >= (64'd1 << (32 - FRAC))) begin
			o.hit_time = '1;
			return o;
		end
		t = ((adr - s) << FRAC) / dvdv;
		o.hit_time = t[31:0];
		return o;
	endfunction

	assign pending = contact_q.size();

	always @(posedge clk or negedge arst_n) begin
		dpct_pkg::out_t want;
		if (!arst_n) begin
			errors <= 0;
			hits_seen <= 0;
			sat_seen <= 0;
			contact_q.delete();
		end else begin
			if (in_valid && !in_stall)
				contact_q.push_back(contact_time(in_data));
			if (out_valid && !out_stall) begin
				if (contact_q.size() == 0) begin
					$display("%0t: unexpected result will_hit=%0b hit_time=%h", $time,
						out_data.will_hit, out_data.hit_time);
					errors <= errors + 1;
				end else begin
					want = contact_q.pop_front();
					if (want.will_hit)
						hits_seen <= hits_seen + 1;
					if (want.hit_time == '1)
						sat_seen <= sat_seen + 1;
					if (want.will_hit !== out_data.will_hit) begin
						$display("%0t: will_hit expected %0b actual %0b", $time,
							want.will_hit, out_data.will_hit);
						errors <= errors + 1;
					end else if (want.hit_time !== out_data.hit_time) begin
						$display("%0t: hit_time expected %h actual %h", $time,
							want.hit_time, out_data.hit_time);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams directed and random disc pairs through the collision time block
// under three idle patterns; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WATCHDOG = 20000;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid = 1'b0;
	logic           in_stall;
	dpct_pkg::in_t  in_data = '0;
	logic           out_valid;
	logic           out_stall = 1'b0;
	dpct_pkg::out_t out_data;
	int   errors, pending, hits_seen, sat_seen;
	int   send_idle = 0, recv_idle = 0;
	int   quiet = 0;
	int   sent = 0;
	dpct_pkg::in_t  pair_list[$];

	always #1 clk = ~clk;

	disc_pair_collision_time_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	dpct_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.errors(errors), .pending(pending), .hits_seen(hits_seen), .sat_seen(sat_seen)
	);

	// receiver stall pattern
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_idle);

	// watchdog on accepted traffic
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > WATCHDOG) begin
			$display("watchdog expired");
			$display("status: fail");
			$finish;
		end
	end

	function automatic dpct_pkg::in_t rand_pair();
		dpct_pkg::in_t p;
		p = '0;
		p.pair_valid = ($urandom_range(15) != 0);
		p.a_pos_x = 20'($urandom);
		p.a_pos_y = 20'($urandom);
		p.b_pos_x = 20'($urandom);
		p.b_pos_y = 20'($urandom);
		p.a_vel_x = 20'($urandom);
		p.a_vel_y = 20'($urandom);
		p.b_vel_x = 20'($urandom);
		p.b_vel_y = 20'($urandom);
		p.a_rad = 19'($urandom);
		p.b_rad = 19'($urandom);
		case ($urandom_range(5))
			0, 1: begin
				// head-on approach along x with nearby discs
				p.b_pos_x = p.a_pos_x + 20'($urandom_range(300000));
				p.b_pos_y = p.a_pos_y + 20'($urandom_range(40000));
				p.a_rad = 19'($urandom_range(100000));
				p.b_rad = 19'($urandom_range(100000));
				p.b_vel_x = -20'sd1 * 20'($urandom_range(200000));
				p.a_vel_x = 20'($urandom_range(200000));
			end
			2: begin
				// slow closing speed for large times
				p.b_vel_x = p.a_vel_x - 20'($urandom_range(3));
				p.b_vel_y = p.a_vel_y;
				p.b_pos_x = p.a_pos_x + 20'($urandom_range(500000));
			end
			3: begin
				// overlapping discs
				p.b_pos_x = p.a_pos_x;
				p.b_pos_y = p.a_pos_y + 20'($urandom_range(1000));
				p.a_rad = 19'($urandom_range(327680));
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic send_pair(dpct_pkg::in_t p);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	initial begin
		dpct_pkg::in_t p;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pairs: invalid, apart, still, extremes, overlap, saturation
		p = '0; pair_list.push_back(p);
		p = '1; pair_list.push_back(p);
		p = '0; p.pair_valid = 1; pair_list.push_back(p);
		p = '0; p.pair_valid = 1; p.b_pos_x = 20'd200000; p.b_vel_x = 20'sd65536;
		pair_list.push_back(p);
		p = '0; p.pair_valid = 1; p.b_pos_x = 20'd200000; p.b_vel_x = -20'sd65536;
		p.a_rad = 19'd32768; p.b_rad = 19'd32768; pair_list.push_back(p);
		p = '0; p.pair_valid = 1; p.b_pos_x = 20'd200000; p.b_pos_y = 20'd400000;
		p.b_vel_x = -20'sd65536; pair_list.push_back(p);
		p = '0; p.pair_valid = 1; p.b_pos_x = 20'd1000; p.b_vel_x = -20'sd1;
		p.a_rad = 19'd327680; pair_list.push_back(p);
		p = '0; p.pair_valid = 1; p.b_pos_x = 20'hFFFFF; p.b_vel_x = -20'sd1;
		pair_list.push_back(p);
		p = '0; p.pair_valid = 1; p.b_pos_x = 20'd655359; p.b_pos_y = 20'd655359;
		p.a_vel_x = 20'sd524287; p.a_vel_y = 20'sd524287;
		p.b_vel_x = -20'sd524288; p.b_vel_y = -20'sd524288;
		p.a_rad = 19'h7FFFF; p.b_rad = 19'h7FFFF; pair_list.push_back(p);
		p = '0; p.pair_valid = 1; p.a_pos_x = 20'hFFFFF; p.a_pos_y = 20'hFFFFF;
		p.a_vel_x = 20'sd524287; p.a_vel_y = 20'sd524287;
		p.b_vel_x = -20'sd524288; p.b_vel_y = -20'sd524288;
		p.a_rad = 19'd327680; p.b_rad = 19'd327680; pair_list.push_back(p);
		p = '0; p.pair_valid = 1; p.b_pos_x = 20'd131072; p.b_vel_x = -20'sd131072;
		p.a_rad = 19'd32768; p.b_rad = 19'd32768; pair_list.push_back(p);
		foreach (pair_list[i])
			send_pair(pair_list[i]);

		// three idle phases of random pairs
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 38 : (ph == 1) ? 62 : 0;
			recv_idle = (ph == 0) ? 62 : (ph == 1) ? 38 : 0;
			for (int n = 0; n < 470; n++)
				send_pair(rand_pair());
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("sent %0d pairs, %0d predicted contacts, %0d saturated times",
			sent, hits_seen, sat_seen);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// File: filelist.f
rtl/dpct_pkg.sv
rtl/dpct_isqrt.sv
rtl/dpct_div.sv
rtl/disc_pair_collision_time_top.sv
sim/dpct_checker.sv
sim/testbench.sv
